// ===== rtl/pixel_tone_map_chroma_boost_unit_defines.svh =====
// assertion macros for the tone map and chroma boost unit
`ifndef PIXEL_TONE_MAP_CHROMA_BOOST_UNIT_DEFINES_SVH
`define PIXEL_TONE_MAP_CHROMA_BOOST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PTMCB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PTMCB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTMCB_ASSERT_IMP(name, ante, cons, msg)
`define PTMCB_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

// ===== rtl/ptmcb_pkg.sv =====
// shared types and constants for the tone map and chroma boost unit
package ptmcb_pkg;

  localparam int unsigned ToneEntriesDefault = 2048;

  localparam int unsigned AccWidth    = 16;
  localparam int unsigned AccFrac     = 12;
  localparam int unsigned GainWidth   = 12;
  localparam int unsigned BoostWidth  = 10;
  localparam int unsigned LevelWidth  = 8;
  localparam int unsigned CfgIdxWidth = 4;
  localparam int unsigned CfgDataWidth = 12;

  localparam logic [GainWidth-1:0]  GainReset  = 12'd660;
  localparam logic [BoostWidth-1:0] BoostReset = 10'd525;

  // floor(x/3) as (x * Recip3) >> Recip3Shift, exact for x below 2^19
  localparam int unsigned Recip3Shift = 20;
  localparam int unsigned Recip3Width = 19;
  localparam int unsigned Recip3      = ((1 << Recip3Shift) + 2) / 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_GAIN         = 4'd0,
    CFG_CHROMA_BOOST = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [AccWidth-1:0] acc_red;
    logic [AccWidth-1:0] acc_green;
    logic [AccWidth-1:0] acc_blue;
  } in_t;

  typedef struct packed {
    logic [LevelWidth-1:0] out_red;
    logic [LevelWidth-1:0] out_green;
    logic [LevelWidth-1:0] out_blue;
  } out_t;

endpackage

// ===== rtl/pixel_tone_map_chroma_boost_unit.sv =====
// top level of the tone map and chroma boost unit
//
// Usage: a pixel of three Q4.12 light accumulators is handed over on in_data and
// taken as a transaction at a rising edge where start is high and busy is low.
// busy is high only in the cycle after reset, so a new pixel can be started in
// every cycle: throughput is one pixel per clock.
// Each pixel yields one result on out_data, marked by out_valid for exactly one
// cycle. Stages: input register, gain multiply and index, tone rom read, mean,
// boost multiply, clamp to the output register. The receiver cannot stall the
// unit, so results leave in order with no back pressure and no storage beyond
// the pipeline.
// Configuration: cfg_index selects gain or chroma boost, cfg_data carries the
// value, taken when cfg_valid and cfg_ready are both high; unknown indexes are
// dropped. Writes are meant for an idle pipeline.
// Reset (rst_n low, synchronous) empties the pipeline and restores the gain
// and boost defaults; the tone curve is a constant rom and needs no fill.
`include "pixel_tone_map_chroma_boost_unit_defines.svh"

module pixel_tone_map_chroma_boost_unit import ptmcb_pkg::*; #(
  parameter int unsigned TONE_ENTRIES = ToneEntriesDefault
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  in_t                     in_data,
  output logic                    out_valid,
  output out_t                    out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  localparam int unsigned Chans    = 3;
  localparam int unsigned SumWidth = LevelWidth + 2;
  localparam int unsigned MeanWidth = 2 * LevelWidth;
  localparam int unsigned ScaledWidth = SumWidth + LevelWidth;
  localparam int unsigned MeanProdWidth = ScaledWidth + Recip3Width;
  localparam int unsigned DiffWidth = MeanWidth + 2;
  localparam int unsigned ValWidth  = DiffWidth + BoostWidth;

  logic                   busy_r;
  logic [GainWidth-1:0]   gain_r;
  logic [BoostWidth-1:0]  boost_r;
  logic                   accept;

  in_t                    in_r;
  logic                   v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [LevelWidth-1:0]  tone      [Chans];
  logic [LevelWidth-1:0]  tone_d_r  [Chans];
  logic [AccWidth-1:0]    acc       [Chans];
  logic [SumWidth-1:0]    sum;
  logic [MeanProdWidth-1:0] mean_prod;
  logic [MeanWidth-1:0]   mean_nxt;
  logic [MeanWidth-1:0]   mean_r;
  logic signed [DiffWidth-1:0] diff  [Chans];
  logic signed [ValWidth-1:0]  val_nxt [Chans];
  logic signed [ValWidth-1:0]  val_r   [Chans];
  logic [LevelWidth-1:0]  lvl_nxt   [Chans];
  logic                   out_valid_r;
  out_t                   out_r;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GainReset;
      boost_r <= BoostReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN:         gain_r  <= cfg_data[GainWidth-1:0];
        CFG_CHROMA_BOOST: boost_r <= cfg_data[BoostWidth-1:0];
        default: ;
      endcase
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      v0_r        <= accept;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  assign acc[0] = in_r.acc_red;
  assign acc[1] = in_r.acc_green;
  assign acc[2] = in_r.acc_blue;

  for (genvar c = 0; c < Chans; c++) begin : g_chan
    ptmcb_lookup #(
      .TONE_ENTRIES (TONE_ENTRIES)
    ) u_lookup (
      .clk  (clk),
      .acc  (acc[c]),
      .gain (gain_r),
      .tone (tone[c])
    );
  end

  // mean of the three levels, Q8
  always_comb begin
    sum       = SumWidth'(tone[0]) + SumWidth'(tone[1]) + SumWidth'(tone[2]);
    mean_prod = MeanProdWidth'({sum, 8'h00}) * MeanProdWidth'(Recip3);
    mean_nxt  = mean_prod[Recip3Shift +: MeanWidth];
  end

  always_ff @(posedge clk) begin
    mean_r <= mean_nxt;
    for (int c = 0; c < Chans; c++) begin
      tone_d_r[c] <= tone[c];
    end
  end

  // push each level away from the mean, Q16
  always_comb begin
    for (int c = 0; c < Chans; c++) begin
      diff[c]    = $signed({2'b00, tone_d_r[c], 8'h00}) - $signed({2'b00, mean_r});
      val_nxt[c] = diff[c] * $signed({1'b0, boost_r})
                 + $signed({4'b0000, mean_r, 8'h00});
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < Chans; c++) begin
      val_r[c] <= val_nxt[c];
    end
  end

  // floor and clamp to 0..255
  always_comb begin
    for (int c = 0; c < Chans; c++) begin
      priority if (val_r[c][ValWidth-1]) begin
        lvl_nxt[c] = '0;
      end else if (val_r[c][ValWidth-2:24] != '0) begin
        lvl_nxt[c] = '1;
      end else begin
        lvl_nxt[c] = val_r[c][23:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r.out_red   <= lvl_nxt[0];
    out_r.out_green <= lvl_nxt[1];
    out_r.out_blue  <= lvl_nxt[2];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PTMCB_ASSERT_IMP(a_latency, accept, ##6 out_valid, "result missing six edges after start")
  `PTMCB_ASSERT_IMP(a_no_spurious, out_valid, $past(accept, 6), "result without a started pixel")
  `PTMCB_ASSERT_IMP(a_grey_mean,
    v3_r && tone_d_r[0] == tone_d_r[1] && tone_d_r[1] == tone_d_r[2],
    mean_r == {tone_d_r[0], 8'h00}, "mean of equal levels is off")

endmodule

// ===== rtl/ptmcb_lookup.sv =====
// one channel: gain multiply, index saturation and registered tone rom read
module ptmcb_lookup import ptmcb_pkg::*; #(
  parameter int unsigned TONE_ENTRIES = ToneEntriesDefault
) (
  input  logic                  clk,
  input  logic [AccWidth-1:0]   acc,
  input  logic [GainWidth-1:0]  gain,
  output logic [LevelWidth-1:0] tone
);

  localparam int unsigned IdxWidth  = $clog2(TONE_ENTRIES);
  localparam int unsigned ProdWidth = AccWidth + GainWidth;
  localparam int unsigned RowLen    = 64;
  localparam logic [63:0] Q60One    = 64'd1 << 60;
  localparam logic [63:0] ToneStep  = (64'd5 << 60) / TONE_ENTRIES;

  typedef logic [LevelWidth-1:0] tone_rom_t [TONE_ENTRIES];

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] div_small(logic [63:0] n, logic [4:0] d);
    logic [63:0] q;
    logic [5:0]  rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[4:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tone_rom_t build_tone(logic [63:0] x);
    tone_rom_t   rom;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] v;
    logic [63:0] lvl;
    term = Q60One;
    pos  = Q60One;
    neg  = '0;
    // exp(-x) by alternating series
    for (int k = 1; k <= 16; k++) begin
      term = div_small(mul_q60(term, x), 5'(k));
      if (k % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    r = pos - neg;
    e = Q60One;
    // filled in rows of RowLen entries
    for (int row = 0; row < TONE_ENTRIES; row += RowLen) begin
      for (int j = 0; j < RowLen; j++) begin
        if (row + j < TONE_ENTRIES) begin
          v            = (e >= Q60One) ? 64'd0 : (Q60One - e);
          lvl          = 64'd255 * (v >> 4);
          rom[row + j] = lvl[63:56];
          e            = mul_q60(e, r);
        end
      end
    end
    return rom;
  endfunction

  localparam tone_rom_t ToneRom = build_tone(ToneStep);

  logic [ProdWidth-1:0] prod;
  logic [AccWidth-1:0]  idx_full;
  logic [IdxWidth-1:0]  idx_nxt;
  logic [IdxWidth-1:0]  idx_r;
  logic [LevelWidth-1:0] tone_r;

  always_comb begin
    prod     = ProdWidth'(acc) * ProdWidth'(gain);
    idx_full = prod[ProdWidth-1:AccFrac];
    if (idx_full > AccWidth'(TONE_ENTRIES - 1)) begin
      idx_nxt = IdxWidth'(TONE_ENTRIES - 1);
    end else begin
      idx_nxt = idx_full[IdxWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    tone_r <= ToneRom[idx_r];
  end

  assign tone = tone_r;

endmodule
